/* sv/hsv2rgb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types, constants and helpers for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int HueW    = 17;
  localparam int UnitInW = 10;
  localparam int UnitW   = 9;   // clamped 0..256
  localparam int ByteW   = 8;
  localparam int FracW   = 10;
  localparam int SectW   = 3;
  localparam int ChanW   = 27;  // channel with 26 fraction bits, 0..2^26

  localparam logic [UnitW-1:0]   UnitOne  = 9'd256;
  localparam logic [FracW:0]     FracOne  = 11'd1024;
  localparam logic [18:0]        ProdOne  = 19'h40000;  // 1.0 with 18 fraction bits
  // floor(x/15) = (x * Recip15) >> 15 for x < 1024
  localparam logic [11:0]        Recip15  = 12'd2185;
  // floor(q/6) = (q * Recip6) >> 8 for q < 69
  localparam logic [5:0]         Recip6   = 6'd43;

  typedef enum logic [SectW-1:0] {
    SECT_RED_YEL  = 3'd0,
    SECT_YEL_GRN  = 3'd1,
    SECT_GRN_CYN  = 3'd2,
    SECT_CYN_BLU  = 3'd3,
    SECT_BLU_MAG  = 3'd4,
    SECT_MAG_RED  = 3'd5
  } sector_t;

  // hue decomposition result handed to the channel math
  typedef struct packed {
    sector_t          sector;
    logic [FracW-1:0] frac;
    logic [UnitW-1:0] sat;
    logic [UnitW-1:0] val;
  } hue_sect_t;

  function automatic logic [UnitW-1:0] clamp_unit(input logic [UnitInW-1:0] x);
    logic [UnitW-1:0] r;
    if (x[UnitInW-1]) begin
      r = '0;
    end else if (x[UnitW-1:0] > UnitOne) begin
      r = UnitOne;
    end else begin
      r = x[UnitW-1:0];
    end
    return r;
  endfunction

endpackage

/* sv/hsv2rgb_hsv_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_hsv_if
// Valid/ready channel carrying one HSV color request.
// ----------------------------------------------------------------------------
interface hsv2rgb_hsv_if;
  logic                                           valid;
  logic                                           ready;
  logic signed [hsv2rgb_pkg::HueW-1:0]            hue;
  logic signed [hsv2rgb_pkg::UnitInW-1:0]         saturation;
  logic signed [hsv2rgb_pkg::UnitInW-1:0]         brightness_value;

  modport source (output valid, hue, saturation, brightness_value, input ready);
  modport sink   (input valid, hue, saturation, brightness_value, output ready);
endinterface

/* sv/hsv2rgb_rgb_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_rgb_if
// Valid/ready channel carrying one RGB pixel request.
// ----------------------------------------------------------------------------
interface hsv2rgb_rgb_if;
  logic                            valid;
  logic                            ready;
  logic [hsv2rgb_pkg::ByteW-1:0]   red;
  logic [hsv2rgb_pkg::ByteW-1:0]   green;
  logic [hsv2rgb_pkg::ByteW-1:0]   blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

/* sv/hsv2rgb_hue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_hue
// Three-stage hue split: clamp, sector index and 10-bit sector fraction.
// ----------------------------------------------------------------------------
module hsv2rgb_hue (
  input  logic                    clk,
  input  logic                    rst,
  hsv2rgb_hsv_if.sink             hsv_in,
  output logic                    sect_valid,
  input  logic                    sect_ready,
  output hsv2rgb_pkg::hue_sect_t  sect
);

  // stage 1: clamped inputs, coarse quotient h/960
  logic                             s1_vld;
  logic [6:0]                       s1_quot;
  logic [9:0]                       s1_hi;
  logic [5:0]                       s1_lo;
  logic [hsv2rgb_pkg::UnitW-1:0]    s1_sat, s1_val;
  // stage 2: remainder and sector
  logic                             s2_vld;
  logic [9:0]                       s2_rem;
  hsv2rgb_pkg::sector_t             s2_sector;
  logic [hsv2rgb_pkg::UnitW-1:0]    s2_sat, s2_val;
  // stage 3: fraction
  logic                             s3_vld;

  logic s1_adv, s2_adv, s3_adv;
  logic [15:0] hue_pos;
  logic [21:0] quot_prod;
  logic [9:0]  quot_x15;
  logic [9:0]  hi_rem;
  logic [11:0] six_prod;
  logic [3:0]  six_quot;
  logic [6:0]  sect_full;
  logic [21:0] rem_prod;
  logic [10:0] frac_sum;

  assign s3_adv       = !s3_vld || sect_ready;
  assign s2_adv       = !s2_vld || s3_adv;
  assign s1_adv       = !s1_vld || s2_adv;
  assign hsv_in.ready = s1_adv;
  assign sect_valid   = s3_vld;

  // 960 = 64 * 15, so divide the upper bits by 15
  always_comb begin
    hue_pos   = hsv_in.hue[16] ? 16'd0 : hsv_in.hue[15:0];
    quot_prod = {12'd0, hue_pos[15:6]} * {10'd0, hsv2rgb_pkg::Recip15};
  end

  always_comb begin
    quot_x15  = {3'd0, s1_quot} * 10'd15;
    hi_rem    = s1_hi - quot_x15;
    six_prod  = {5'd0, s1_quot} * {6'd0, hsv2rgb_pkg::Recip6};
    six_quot  = six_prod[11:8];
    sect_full = s1_quot - ({3'd0, six_quot} * 7'd6);
  end

  // f = rem * 16 / 15 = rem + rem / 15
  always_comb begin
    rem_prod = {12'd0, s2_rem} * {10'd0, hsv2rgb_pkg::Recip15};
    frac_sum = {1'b0, s2_rem} + {4'd0, rem_prod[21:15]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
    end else begin
      if (s1_adv) s1_vld <= hsv_in.valid;
      if (s2_adv) s2_vld <= s1_vld;
      if (s3_adv) s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_quot <= quot_prod[21:15];
      s1_hi   <= hue_pos[15:6];
      s1_lo   <= hue_pos[5:0];
      s1_sat  <= hsv2rgb_pkg::clamp_unit(hsv_in.saturation);
      s1_val  <= hsv2rgb_pkg::clamp_unit(hsv_in.brightness_value);
    end
    if (s2_adv) begin
      s2_rem    <= {hi_rem[3:0], s1_lo};
      s2_sector <= hsv2rgb_pkg::sector_t'(sect_full[2:0]);
      s2_sat    <= s1_sat;
      s2_val    <= s1_val;
    end
    if (s3_adv) begin
      sect.frac   <= frac_sum[9:0];
      sect.sector <= s2_sector;
      sect.sat    <= s2_sat;
      sect.val    <= s2_val;
    end
  end

endmodule

/* sv/hsv2rgb_chan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_chan
// Three-stage channel math: s*f terms, v products, sector routing and scale.
// ----------------------------------------------------------------------------
module hsv2rgb_chan (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    sect_valid,
  output logic                    sect_ready,
  input  hsv2rgb_pkg::hue_sect_t  sect,
  hsv2rgb_rgb_if.source           rgb_out
);

  localparam int CW = hsv2rgb_pkg::ChanW;

  // stage 4: saturation products
  logic                             s4_vld;
  logic [17:0]                      s4_sf;
  logic [18:0]                      s4_sfc;
  logic [16:0]                      s4_pv;
  logic [hsv2rgb_pkg::UnitW-1:0]    s4_val;
  hsv2rgb_pkg::sector_t             s4_sector;
  // stage 5: value products
  logic                             s5_vld;
  logic [CW-1:0]                    s5_q, s5_t;
  logic [16:0]                      s5_pv;
  logic [hsv2rgb_pkg::UnitW-1:0]    s5_val;
  hsv2rgb_pkg::sector_t             s5_sector;
  // stage 6: output register
  logic                             s6_vld;

  logic s4_adv, s5_adv, s6_adv;
  logic [hsv2rgb_pkg::FracW:0] frac_c;
  logic [18:0] q_fac, t_fac;
  logic [27:0] q_prod, t_prod;
  logic [CW-1:0] ch_v, ch_p, ch_r, ch_g, ch_b;
  logic [CW+7:0] sc_r, sc_g, sc_b;

  assign s6_adv        = !s6_vld || rgb_out.ready;
  assign s5_adv        = !s5_vld || s6_adv;
  assign s4_adv        = !s4_vld || s5_adv;
  assign sect_ready    = s4_adv;
  assign rgb_out.valid = s6_vld;

  assign frac_c = hsv2rgb_pkg::FracOne - {1'b0, sect.frac};

  always_comb begin
    q_fac  = hsv2rgb_pkg::ProdOne - {1'b0, s4_sf};
    t_fac  = hsv2rgb_pkg::ProdOne - s4_sfc;
    q_prod = {19'd0, s4_val} * {9'd0, q_fac};
    t_prod = {19'd0, s4_val} * {9'd0, t_fac};
  end

  always_comb begin
    ch_v = {s5_val, 18'd0};
    ch_p = {s5_pv, 10'd0};
    case (s5_sector)
      hsv2rgb_pkg::SECT_RED_YEL: begin ch_r = ch_v; ch_g = s5_t; ch_b = ch_p; end
      hsv2rgb_pkg::SECT_YEL_GRN: begin ch_r = s5_q; ch_g = ch_v; ch_b = ch_p; end
      hsv2rgb_pkg::SECT_GRN_CYN: begin ch_r = ch_p; ch_g = ch_v; ch_b = s5_t; end
      hsv2rgb_pkg::SECT_CYN_BLU: begin ch_r = ch_p; ch_g = s5_q; ch_b = ch_v; end
      hsv2rgb_pkg::SECT_BLU_MAG: begin ch_r = s5_t; ch_g = ch_p; ch_b = ch_v; end
      default:                   begin ch_r = ch_v; ch_g = ch_p; ch_b = s5_q; end
    endcase
    // x * 255 = x * 256 - x
    sc_r = {ch_r, 8'd0} - {8'd0, ch_r};
    sc_g = {ch_g, 8'd0} - {8'd0, ch_g};
    sc_b = {ch_b, 8'd0} - {8'd0, ch_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
      s6_vld <= 1'b0;
    end else begin
      if (s4_adv) s4_vld <= sect_valid;
      if (s5_adv) s5_vld <= s4_vld;
      if (s6_adv) s6_vld <= s5_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_adv) begin
      s4_sf     <= {9'd0, sect.sat} * {8'd0, sect.frac};
      s4_sfc    <= {10'd0, sect.sat} * {8'd0, frac_c};
      s4_pv     <= {8'd0, sect.val} * {8'd0, (hsv2rgb_pkg::UnitOne - sect.sat)};
      s4_val    <= sect.val;
      s4_sector <= sect.sector;
    end
    if (s5_adv) begin
      s5_q      <= q_prod[CW-1:0];
      s5_t      <= t_prod[CW-1:0];
      s5_pv     <= s4_pv;
      s5_val    <= s4_val;
      s5_sector <= s4_sector;
    end
    if (s6_adv) begin
      rgb_out.red   <= sc_r[33:26];
      rgb_out.green <= sc_g[33:26];
      rgb_out.blue  <= sc_b[33:26];
    end
  end

endmodule

/* sv/hsv_to_rgb_pixel_converter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_converter_top
// Streaming HSV to RGB pixel converter, six-stage pipeline.
// ----------------------------------------------------------------------------
// One HSV request in, one RGB request out, no state between pixels. Hue is in
// 1/16 degree (negative clamps to zero, wraps at 360 degrees); saturation and
// brightness are Q8 (256 = 1.0), clamped to 0..1. Each output channel is
// floor(x * 255) of the usual v / p / q / t selection by 60-degree sector.
// Throughput is one pixel per clock while the output is ready; an accepted
// request passes through every stage register before output valid rises. The
// pipeline has six register stages with a valid bit each: three in the hue
// splitter and three in the channel math, the last of which is the output
// register. A stalled stage holds while bubbles ahead of it still fill, so the
// input keeps taking requests while a finished pixel waits at the output,
// until every stage holds one.
// ----------------------------------------------------------------------------
module hsv_to_rgb_pixel_converter_top (
  input  logic            clk,
  input  logic            rst,
  hsv2rgb_hsv_if.sink     hsv_in,
  hsv2rgb_rgb_if.source   rgb_out
);

  // hue splitter -> channel math
  logic                    sect_valid;
  logic                    sect_ready;
  hsv2rgb_pkg::hue_sect_t  sect;

  // stages 1..3: clamp, h/960 by reciprocal, sector and 10-bit fraction
  hsv2rgb_hue u_hue (
    .clk        (clk),
    .rst        (rst),
    .hsv_in     (hsv_in),
    .sect_valid (sect_valid),
    .sect_ready (sect_ready),
    .sect       (sect)
  );

  // stages 4..6: s*f, v*(1-...), sector routing, *255 and output register
  hsv2rgb_chan u_chan (
    .clk        (clk),
    .rst        (rst),
    .sect_valid (sect_valid),
    .sect_ready (sect_ready),
    .sect       (sect),
    .rgb_out    (rgb_out)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // sector index from the reciprocal reduction stays within six sectors
  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    sect_valid |-> (sect.sector <= hsv2rgb_pkg::SECT_MAG_RED))
    else $error("hue sector out of range");

  // sector fraction never reaches 1.0 and saturation/value stay clamped
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    sect_valid |-> (sect.frac <= 10'd1022 && sect.sat <= hsv2rgb_pkg::UnitOne &&
                    sect.val <= hsv2rgb_pkg::UnitOne))
    else $error("sector fraction or unit value out of range");

  // a request stalled between the two halves keeps its payload
  a_mid_hold: assert property (@(posedge clk) disable iff (rst)
    (sect_valid && !sect_ready) |=> (sect_valid && $stable(sect)))
    else $error("mid-pipeline request changed while stalled");

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!rgb_out.valid && !sect_valid))
    else $error("pipeline valid after reset");

endmodule
